>>> rtl/core/wsfu_pkg.sv
// ----------------------------------------------------------------------------
// wsfu_pkg
// Shared types and constants for the websocket frame unmasker.
// ----------------------------------------------------------------------------
package wsfu_pkg;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_OVERSIZE = 2'd2;

    localparam logic [6:0] LEN_CODE_MASK = 7'h7F;
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4096;
    localparam logic [63:0] FRAME_LENGTH_SAT  = 64'd65535;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        last;
        logic [15:0] frame_length;
    } result_t;

endpackage

>>> rtl/core/websocket_frame_unmasker.sv
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Receive-side frame parser: strips headers and unmasks payload words.
// ----------------------------------------------------------------------------
// Takes the received frame stream one byte word per cycle and gives at most
// one result word per input word, registered on acceptance. Each byte goes
// through a single registered parse/XOR step between the input handshake and
// the output register, so a new word is accepted every cycle; a two-entry
// output register (main plus skid) keeps s_ready independent of m_ready, and
// s_ready drops only while both entries are full. Payload words come out
// unmasked with the frame's length (saturated at 65535) and last set on the
// final word. An empty frame gives one word of kind 1 when its header ends;
// a frame longer than cfg_max_payload, or longer than LENGTH_BITS can count,
// gives one word of kind 2 when its length is complete, and its key and
// payload are dropped. cfg_max_payload (reset 4096) is sampled when a frame's
// length completes and should be written only while the block is idle.
module websocket_frame_unmasker #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_max_payload,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_payload_byte,
    output logic        m_last,
    output logic [15:0] m_frame_length
);

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT     = 3'd2,
        PH_KEY     = 3'd3,
        PH_DATA    = 3'd4,
        PH_SKIPKEY = 3'd5,
        PH_SKIP    = 3'd6
    } phase_t;

    logic [15:0]            max_payload_reg;
    phase_t                 phase_reg, phase_next;
    logic [3:0]             ext_left_reg, ext_left_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic                   too_big_reg, too_big_next;
    logic                   masked_reg, masked_next;
    logic [7:0]             key_reg [4];
    logic [7:0]             key_next [4];
    logic [LENGTH_BITS-1:0] index_reg, index_next;

    wsfu_pkg::result_t      res;
    logic                   res_valid;

    wsfu_pkg::result_t      main_reg, skid_reg;
    logic                   main_valid_reg, skid_valid_reg;

    logic                   accept;
    logic                   pop;
    logic                   len_done;
    logic                   over;
    logic [63:0]            len64;
    logic [15:0]            len_sat;
    logic [15:0]            data_len_sat;
    logic [LENGTH_BITS:0]   index_inc;
    logic                   index_fin;
    logic [1:0]             key_idx;
    logic [6:0]             code;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign pop       = main_valid_reg && m_ready;

    assign index_inc = {1'b0, index_reg} + {{LENGTH_BITS{1'b0}}, 1'b1};
    assign index_fin = index_inc >= {1'b0, length_reg};
    assign key_idx   = 2'(2'd0 - ext_left_reg[1:0]);
    assign code      = s_in_byte[6:0] & wsfu_pkg::LEN_CODE_MASK;

    // saturated length of the frame being passed through
    assign data_len_sat = (too_big_reg || 64'(length_reg) > wsfu_pkg::FRAME_LENGTH_SAT)
                          ? 16'hFFFF : 16'(length_reg);

    always_comb begin
        phase_next    = phase_reg;
        ext_left_next = ext_left_reg;
        length_next   = length_reg;
        too_big_next  = too_big_reg;
        masked_next   = masked_reg;
        index_next    = index_reg;
        for (int i = 0; i < 4; i++) begin
            key_next[i] = key_reg[i];
        end
        res_valid        = 1'b0;
        res.kind         = wsfu_pkg::KIND_DATA;
        res.payload_byte = 8'd0;
        res.last         = 1'b0;
        res.frame_length = 16'd0;
        len_done         = 1'b0;

        unique case (phase_reg)
            PH_HDR0: begin
                phase_next = PH_HDR1;
            end
            PH_HDR1: begin
                masked_next  = s_in_byte[7];
                too_big_next = 1'b0;
                for (int i = 0; i < 4; i++) begin
                    key_next[i] = 8'd0;
                end
                if (code == wsfu_pkg::LEN_CODE_EXT16) begin
                    length_next   = '0;
                    ext_left_next = wsfu_pkg::EXT16_BYTES;
                    phase_next    = PH_EXT;
                end else if (code == wsfu_pkg::LEN_CODE_EXT64) begin
                    length_next   = '0;
                    ext_left_next = wsfu_pkg::EXT64_BYTES;
                    phase_next    = PH_EXT;
                end else begin
                    length_next = LENGTH_BITS'(code);
                    len_done    = 1'b1;
                end
            end
            PH_EXT: begin
                if (length_reg[LENGTH_BITS-1 -: 8] != 8'd0) begin
                    too_big_next = 1'b1;
                end
                if (too_big_next) begin
                    length_next = '1;
                end else begin
                    length_next = LENGTH_BITS'({length_reg, s_in_byte});
                end
                ext_left_next = ext_left_reg - 4'd1;
                if (ext_left_next == 4'd0) begin
                    len_done = 1'b1;
                end
            end
            PH_KEY, PH_SKIPKEY: begin
                key_next[key_idx] = s_in_byte;
                ext_left_next     = ext_left_reg - 4'd1;
                if (ext_left_next == 4'd0) begin
                    if (phase_reg == PH_SKIPKEY) begin
                        phase_next = PH_SKIP;
                    end else if (length_reg == '0) begin
                        phase_next = PH_HDR0;
                        res_valid  = 1'b1;
                        res.kind   = wsfu_pkg::KIND_EMPTY;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                res_valid        = 1'b1;
                res.kind         = wsfu_pkg::KIND_DATA;
                res.payload_byte = s_in_byte ^ key_reg[index_reg[1:0]];
                res.last         = index_fin;
                res.frame_length = data_len_sat;
                if (index_fin) begin
                    phase_next = PH_HDR0;
                    index_next = '0;
                end else begin
                    index_next = index_inc[LENGTH_BITS-1:0];
                end
            end
            PH_SKIP: begin
                if (index_fin) begin
                    phase_next = PH_HDR0;
                    index_next = '0;
                end else begin
                    index_next = index_inc[LENGTH_BITS-1:0];
                end
            end
            default: begin
                phase_next = PH_HDR0;
            end
        endcase

        len64   = 64'(length_next);
        len_sat = (too_big_next || len64 > wsfu_pkg::FRAME_LENGTH_SAT) ? 16'hFFFF
                                                                       : 16'(len64);
        over    = too_big_next || (len64 > 64'(max_payload_reg));

        if (len_done) begin
            index_next = '0;
            if (over) begin
                res_valid        = 1'b1;
                res.kind         = wsfu_pkg::KIND_OVERSIZE;
                res.frame_length = len_sat;
                if (masked_next) begin
                    phase_next    = PH_SKIPKEY;
                    ext_left_next = wsfu_pkg::KEY_BYTES;
                end else begin
                    phase_next = PH_SKIP;
                end
            end else if (masked_next) begin
                phase_next    = PH_KEY;
                ext_left_next = wsfu_pkg::KEY_BYTES;
            end else if (length_next == '0) begin
                phase_next = PH_HDR0;
                res_valid  = 1'b1;
                res.kind   = wsfu_pkg::KIND_EMPTY;
            end else begin
                phase_next = PH_DATA;
            end
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= wsfu_pkg::MAX_PAYLOAD_RESET;
            phase_reg       <= PH_HDR0;
            ext_left_reg    <= 4'd0;
            length_reg      <= '0;
            too_big_reg     <= 1'b0;
            masked_reg      <= 1'b0;
            index_reg       <= '0;
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= 8'd0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_payload_reg <= cfg_max_payload;
            end
            if (accept) begin
                phase_reg    <= phase_next;
                ext_left_reg <= ext_left_next;
                length_reg   <= length_next;
                too_big_reg  <= too_big_next;
                masked_reg   <= masked_next;
                index_reg    <= index_next;
                for (int i = 0; i < 4; i++) begin
                    key_reg[i] <= key_next[i];
                end
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!main_valid_reg || pop) begin
            main_valid_reg <= accept && res_valid;
        end else if (accept && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (!main_valid_reg || pop) begin
            main_reg <= res;
        end else begin
            skid_reg <= res;
        end
    end

    assign m_valid        = main_valid_reg;
    assign m_kind         = main_reg.kind;
    assign m_payload_byte = main_reg.payload_byte;
    assign m_last         = main_reg.last;
    assign m_frame_length = main_reg.frame_length;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for websocket_frame_unmasker. A directed table of frame
// bytes and register writes comes first, then random frames under several
// max_payload settings. Every result word is predicted on input acceptance and
// compared field by field with what the block gives, in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int N_DIRECTED      = 36;

    typedef enum logic [2:0] {
        ST_HDR0, ST_HDR1, ST_EXT, ST_KEY, ST_DATA, ST_SKIPKEY, ST_SKIP
    } parse_state_e;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_op_e;

    typedef struct packed {
        row_op_e           op;
        logic [15:0]       value;
        logic              typed;
        wsfu_pkg::result_t want;
    } stim_row_t;

    localparam wsfu_pkg::result_t NO_WORD    = '0;
    localparam wsfu_pkg::result_t EMPTY_WORD = '{wsfu_pkg::KIND_EMPTY, 8'h00, 1'b0, 16'd0};

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_max_payload = 16'd0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte       = 8'd0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_payload_byte;
    logic        m_last;
    logic [15:0] m_frame_length;

    // frame parser mirror
    parse_state_e pstate       = ST_HDR0;
    logic [3:0]   bytes_due    = 4'd0;
    logic [15:0]  frame_len    = 16'd0;
    logic         len_overflow = 1'b0;
    logic         key_on       = 1'b0;
    logic [7:0]   key_bytes [4] = '{default: 8'h00};
    logic [15:0]  data_idx     = 16'd0;
    logic [15:0]  max_payload_mirror = wsfu_pkg::MAX_PAYLOAD_RESET;

    wsfu_pkg::result_t expected_words [$];
    int      mismatches    = 0;
    int      bytes_counted = 0;
    int      stuck_cycles  = 0;
    int      stall_left    = 0;
    logic    no_idling     = 1'b0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_BYTE, 16'h0081, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0000, 1'b1, EMPTY_WORD},
        '{ROW_BYTE, 16'h0082, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0001, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h00FF, 1'b1, '{wsfu_pkg::KIND_DATA, 8'hFF, 1'b1, 16'd1}},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0084, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0001, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0002, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0004, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0080, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h00FF, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0080, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h007F, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h00FF, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0080, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h00FF, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h00FF, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h00FF, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h00FF, 1'b1, EMPTY_WORD},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h007E, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0000, 1'b1, EMPTY_WORD},
        '{ROW_CFG,  16'h0000, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0001, 1'b1, '{wsfu_pkg::KIND_OVERSIZE, 8'h00, 1'b0, 16'd1}},
        '{ROW_BYTE, 16'h00A5, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0081, 1'b1, '{wsfu_pkg::KIND_OVERSIZE, 8'h00, 1'b0, 16'd1}},
        '{ROW_BYTE, 16'h0011, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0022, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0033, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0044, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0055, 1'b0, NO_WORD}
    };

    websocket_frame_unmasker i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_max_payload (cfg_max_payload),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_payload_byte  (m_payload_byte),
        .m_last          (m_last),
        .m_frame_length  (m_frame_length)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // frame length known: choose key, payload or skip
    function automatic logic length_complete(output wsfu_pkg::result_t w);
        w = NO_WORD;
        data_idx = 16'd0;
        if (len_overflow || frame_len > max_payload_mirror) begin
            if (key_on) begin
                pstate = ST_SKIPKEY;
                bytes_due = wsfu_pkg::KEY_BYTES;
            end else begin
                pstate = ST_SKIP;
            end
            w = '{wsfu_pkg::KIND_OVERSIZE, 8'h00, 1'b0,
                  len_overflow ? 16'hFFFF : frame_len};
            return 1'b1;
        end
        if (key_on) begin
            pstate = ST_KEY;
            bytes_due = wsfu_pkg::KEY_BYTES;
            return 1'b0;
        end
        if (frame_len == 16'd0) begin
            pstate = ST_HDR0;
            w = EMPTY_WORD;
            return 1'b1;
        end
        pstate = ST_DATA;
        return 1'b0;
    endfunction

    function automatic logic deframe_byte(input logic [7:0] b,
                                          output wsfu_pkg::result_t w);
        logic [6:0] code;
        logic [3:0] key_slot;
        logic       fin;
        logic       got;
        w = NO_WORD;
        got = 1'b0;
        case (pstate)
            ST_HDR0: begin
                pstate = ST_HDR1;
            end
            ST_HDR1: begin
                key_on = b[7];
                key_bytes = '{default: 8'h00};
                len_overflow = 1'b0;
                frame_len = 16'd0;
                code = b[6:0] & wsfu_pkg::LEN_CODE_MASK;
                if (code == wsfu_pkg::LEN_CODE_EXT16) begin
                    bytes_due = wsfu_pkg::EXT16_BYTES;
                    pstate = ST_EXT;
                end else if (code == wsfu_pkg::LEN_CODE_EXT64) begin
                    bytes_due = wsfu_pkg::EXT64_BYTES;
                    pstate = ST_EXT;
                end else begin
                    frame_len = {9'd0, code};
                    got = length_complete(w);
                end
            end
            ST_EXT: begin
                if (frame_len[15:8] != 8'd0) len_overflow = 1'b1;
                frame_len = len_overflow ? 16'hFFFF : {frame_len[7:0], b};
                bytes_due = bytes_due - 4'd1;
                if (bytes_due == 4'd0) got = length_complete(w);
            end
            ST_KEY, ST_SKIPKEY: begin
                key_slot = wsfu_pkg::KEY_BYTES - bytes_due;
                key_bytes[key_slot[1:0]] = b;
                bytes_due = bytes_due - 4'd1;
                if (bytes_due == 4'd0) begin
                    if (pstate == ST_SKIPKEY) begin
                        pstate = ST_SKIP;
                    end else if (frame_len == 16'd0) begin
                        pstate = ST_HDR0;
                        w = EMPTY_WORD;
                        got = 1'b1;
                    end else begin
                        pstate = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                fin = ({1'b0, data_idx} + 17'd1) >= {1'b0, frame_len};
                w = '{wsfu_pkg::KIND_DATA, b ^ key_bytes[data_idx[1:0]], fin,
                      len_overflow ? 16'hFFFF : frame_len};
                got = 1'b1;
                data_idx = data_idx + 16'd1;
                if (fin) begin
                    pstate = ST_HDR0;
                    data_idx = 16'd0;
                end
            end
            ST_SKIP: begin
                if (({1'b0, data_idx} + 17'd1) >= {1'b0, frame_len}) begin
                    pstate = ST_HDR0;
                    data_idx = 16'd0;
                end else begin
                    data_idx = data_idx + 16'd1;
                end
            end
            default: begin
                pstate = ST_HDR0;
            end
        endcase
        return got;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        $display("%0t mismatch %s: expected %0h got %0h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic use_typed = 1'b0,
                             input wsfu_pkg::result_t typed_word = '0);
        wsfu_pkg::result_t w;
        logic    got;
        if (!no_idling && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_counted++;
        got = deframe_byte(b, w);
        if (use_typed) expected_words.push_back(typed_word);
        else if (got) expected_words.push_back(w);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_payload(input logic [15:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_max_payload <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        max_payload_mirror = v;
    endtask

    // random bytes, then whatever the parser still needs to get back to a header;
    // extended length bytes stay small so a cut header cannot run away
    task automatic send_noise(input int n);
        repeat (n) send_byte((pstate == ST_EXT) ? 8'h00 : 8'($urandom()));
        while (pstate != ST_HDR0)
            send_byte((pstate == ST_EXT && bytes_due > 4'd1) ? 8'h00 : 8'($urandom()));
    endtask

    // a huge frame stops after its header, leaving the parser skipping
    task automatic send_frame(input logic [15:0] len, input logic huge);
        logic [7:0] hdr [$];
        logic       mask_bit;
        int         keep;
        mask_bit = 1'($urandom_range(0, 1));
        hdr.push_back(8'($urandom()));
        if (huge) begin
            hdr.push_back({mask_bit, wsfu_pkg::LEN_CODE_EXT64});
            hdr.push_back(8'($urandom_range(1, 255)));
            repeat (7) hdr.push_back(8'($urandom()));
        end else if (len <= 16'd125 && $urandom_range(0, 3) != 0) begin
            hdr.push_back({mask_bit, len[6:0]});
        end else if ($urandom_range(0, 1) == 0) begin
            hdr.push_back({mask_bit, wsfu_pkg::LEN_CODE_EXT16});
            hdr.push_back(len[15:8]);
            hdr.push_back(len[7:0]);
        end else begin
            hdr.push_back({mask_bit, wsfu_pkg::LEN_CODE_EXT64});
            repeat (6) hdr.push_back(8'h00);
            hdr.push_back(len[15:8]);
            hdr.push_back(len[7:0]);
        end
        keep = hdr.size();
        if (!huge && $urandom_range(0, 15) == 0) keep = $urandom_range(1, hdr.size() - 1);
        for (int i = 0; i < keep; i++) send_byte(hdr[i]);
        if (!huge) send_noise(0);
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!no_idling && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        wsfu_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                flag_mismatch("unexpected word, kind", 0, m_kind);
            end else begin
                want = expected_words.pop_front();
                if (m_kind != want.kind) flag_mismatch("kind", want.kind, m_kind);
                if (m_payload_byte != want.payload_byte)
                    flag_mismatch("payload_byte", want.payload_byte, m_payload_byte);
                if (m_last != want.last) flag_mismatch("last", want.last, m_last);
                if (m_frame_length != want.frame_length)
                    flag_mismatch("frame_length", want.frame_length, m_frame_length);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        logic [15:0] len;
        logic [15:0] phase_limit;
        int          target;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG)
                write_max_payload(directed_rows[i].value);
            else
                send_byte(directed_rows[i].value[7:0], directed_rows[i].typed,
                          directed_rows[i].want);
        end

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: phase_limit = 16'hFFFF;
                1: phase_limit = 16'd1;
                2: phase_limit = 16'd20;
                3: phase_limit = 16'd0;
                4: phase_limit = 16'($urandom_range(0, 300));
                default: phase_limit = 16'd8;
            endcase
            write_max_payload(phase_limit);
            if (p == 5) no_idling <= 1'b1;
            target = bytes_counted + ITEMS_PER_PHASE;
            while (bytes_counted < target) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_noise($urandom_range(1, 4));
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: len = 16'($urandom_range(0, 12));
                        6, 7: begin
                            if (max_payload_mirror <= 16'd290)
                                len = ((max_payload_mirror == 16'd0) ? 16'd0
                                       : max_payload_mirror - 16'd1)
                                      + 16'($urandom_range(0, 2));
                            else
                                len = 16'($urandom_range(0, 300));
                        end
                        8: len = 16'($urandom_range(13, 300));
                        default: len = 16'($urandom_range(124, 127));
                    endcase
                    send_frame(len, 1'b0);
                end
            end
        end

        send_frame(16'd0, 1'b1);

        drain_results();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
